/* sv/rdp_pkg.sv */
package rdp_pkg;

   // parser phase
   typedef enum logic [2:0] {
      PH_TAG,
      PH_LEN_LO,
      PH_LEN_HI,
      PH_BODY,
      PH_HALT
   } phase_type;

   // record kinds
   localparam logic [1:0] KIND_IRQ = 2'd0;
   localparam logic [1:0] KIND_IO  = 2'd1;
   localparam logic [1:0] KIND_MEM = 2'd2;
   localparam logic [1:0] KIND_END = 2'd3;

   // descriptor tag decoding
   localparam logic [3:0] STYPE_IRQ = 4'd4;
   localparam logic [3:0] STYPE_IO  = 4'd8;
   localparam logic [3:0] STYPE_END = 4'd15;
   localparam logic [7:0] TAG_MEM32 = 8'h85;

   // body byte positions of interest
   localparam logic [15:0] POS_IRQ_MASK_HI = 16'd1;
   localparam logic [15:0] POS_IO_MIN_LO   = 16'd1;
   localparam logic [15:0] POS_IO_MIN_HI   = 16'd2;
   localparam logic [15:0] POS_IO_MAX_LO   = 16'd3;
   localparam logic [15:0] POS_IO_MAX_HI   = 16'd4;
   localparam logic [15:0] POS_IO_LEN      = 16'd6;
   localparam logic [15:0] POS_MEM_MIN_LO  = 16'd1;
   localparam logic [15:0] POS_MEM_MIN_HI  = 16'd4;
   localparam logic [15:0] POS_MEM_MAX_LO  = 16'd5;
   localparam logic [15:0] POS_MEM_MAX_HI  = 16'd8;
   localparam logic [15:0] POS_MEM_LEN_LO  = 16'd13;
   localparam logic [15:0] POS_MEM_LEN_HI  = 16'd16;

   // result queue
   localparam int QUEUE_DEPTH = 4;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] range_start;
      logic [31:0] range_end;
      logic [6:0]  entry_number;
      logic        last_result;
   } result_type;

   // results of one byte, in delivery order
   typedef struct packed {
      logic [1:0] push_n;
      result_type word0;
      result_type word1;
   } parse_out_type;

   // index of the lowest set bit of a 16-bit irq mask
   function automatic logic [3:0] lowest_set(input logic [15:0] mask);
      logic [3:0] idx;
      idx = 4'd0;
      for (int i = 15; i >= 0; i--) begin
         if (mask[i]) begin
            idx = 4'(i);
         end
      end
      return idx;
   endfunction

endpackage

/* sv/rdp_if.sv */
interface rdp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface rdp_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [31:0] range_start;
   logic [31:0] range_end;
   logic [6:0]  entry_number;
   logic        last_result;

   modport source (output valid, output kind, output range_start, output range_end,
                   output entry_number, output last_result, input ready);
   modport sink (input valid, input kind, input range_start, input range_end,
                 input entry_number, input last_result, output ready);
endinterface

/* sv/rdp_parse.sv */
module rdp_parse #(
   parameter int MaxResources = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic [7:0]            data_byte,
   input  logic                  last_byte,
   output rdp_pkg::parse_out_type parse_out
);

   rdp_pkg::phase_type phase_ff, phase_in;
   logic [7:0]  tag_ff, tag_in;
   logic [15:0] len_ff, len_in;
   logic [15:0] pos_ff, pos_in;
   logic [31:0] min_ff, min_in;
   logic [31:0] max_ff, max_in;
   logic [31:0] flen_ff, flen_in;
   logic [6:0]  count_ff, count_in;

   logic        small_tag;
   logic [3:0]  stype;
   logic [15:0] pos_inc;
   logic [15:0] len_hi;
   logic [15:0] line_bits;
   logic [1:0]  byte_sel;
   logic [6:0]  count_after;
   logic        rec_valid;
   logic        stop_valid;
   logic        halted;
   rdp_pkg::result_type rec_word;
   rdp_pkg::result_type stop_word;

   always_comb begin
      phase_in    = phase_ff;
      tag_in      = tag_ff;
      len_in      = len_ff;
      pos_in      = pos_ff;
      min_in      = min_ff;
      max_in      = max_ff;
      flen_in     = flen_ff;
      count_in    = count_ff;
      rec_valid   = 1'b0;
      stop_valid  = 1'b0;
      halted      = 1'b0;
      rec_word    = '0;
      small_tag   = ~tag_ff[7];
      stype       = tag_ff[6:3];
      pos_inc     = pos_ff + 16'd1;
      len_hi      = {data_byte, len_ff[7:0]};
      line_bits   = {data_byte, min_ff[7:0]};
      // byte lane within a 32-bit field: positions 1..4, 5..8, 13..16 map to 0..3
      byte_sel    = 2'(pos_ff[1:0] - 2'd1);

      unique case (phase_ff)
         rdp_pkg::PH_HALT: begin
            halted = 1'b1;
         end
         rdp_pkg::PH_TAG: begin
            tag_in  = data_byte;
            len_in  = '0;
            pos_in  = '0;
            min_in  = '0;
            max_in  = '0;
            flen_in = '0;
            if (!data_byte[7]) begin
               if (data_byte[6:3] == rdp_pkg::STYPE_END) begin
                  stop_valid = 1'b1;
                  halted     = 1'b1;
                  phase_in   = rdp_pkg::PH_HALT;
               end else if (data_byte[2:0] != 3'd0) begin
                  len_in   = {13'd0, data_byte[2:0]};
                  phase_in = rdp_pkg::PH_BODY;
               end
            end else begin
               phase_in = rdp_pkg::PH_LEN_LO;
            end
         end
         rdp_pkg::PH_LEN_LO: begin
            len_in   = {8'd0, data_byte};
            phase_in = rdp_pkg::PH_LEN_HI;
         end
         rdp_pkg::PH_LEN_HI: begin
            len_in   = len_hi;
            phase_in = (len_hi == 16'd0) ? rdp_pkg::PH_TAG : rdp_pkg::PH_BODY;
         end
         rdp_pkg::PH_BODY: begin
            if (small_tag && stype == rdp_pkg::STYPE_IRQ) begin
               if (pos_ff == 16'd0) begin
                  min_in = {24'd0, data_byte};
               end else if (pos_ff == rdp_pkg::POS_IRQ_MASK_HI && line_bits != 16'd0) begin
                  rec_valid            = 1'b1;
                  rec_word.kind        = rdp_pkg::KIND_IRQ;
                  rec_word.range_start = {28'd0, rdp_pkg::lowest_set(line_bits)};
                  rec_word.range_end   = {28'd0, rdp_pkg::lowest_set(line_bits)};
               end
            end else if (small_tag && stype == rdp_pkg::STYPE_IO) begin
               if (pos_ff == rdp_pkg::POS_IO_MIN_LO) begin
                  min_in[7:0] = data_byte;
               end else if (pos_ff == rdp_pkg::POS_IO_MIN_HI) begin
                  min_in[15:8] = data_byte;
               end else if (pos_ff == rdp_pkg::POS_IO_MAX_LO) begin
                  max_in[7:0] = data_byte;
               end else if (pos_ff == rdp_pkg::POS_IO_MAX_HI) begin
                  max_in[15:8] = data_byte;
               end else if (pos_ff == rdp_pkg::POS_IO_LEN) begin
                  flen_in              = {24'd0, data_byte};
                  rec_valid            = 1'b1;
                  rec_word.kind        = rdp_pkg::KIND_IO;
                  rec_word.range_start = min_ff;
                  rec_word.range_end   = max_ff + {24'd0, data_byte} - 32'd1;
               end
            end else if (tag_ff == rdp_pkg::TAG_MEM32) begin
               if (pos_ff >= rdp_pkg::POS_MEM_MIN_LO && pos_ff <= rdp_pkg::POS_MEM_MIN_HI) begin
                  min_in[8*byte_sel +: 8] = data_byte;
               end else if (pos_ff >= rdp_pkg::POS_MEM_MAX_LO &&
                            pos_ff <= rdp_pkg::POS_MEM_MAX_HI) begin
                  max_in[8*byte_sel +: 8] = data_byte;
               end else if (pos_ff >= rdp_pkg::POS_MEM_LEN_LO &&
                            pos_ff <= rdp_pkg::POS_MEM_LEN_HI) begin
                  flen_in[8*byte_sel +: 8] = data_byte;
                  if (pos_ff == rdp_pkg::POS_MEM_LEN_HI) begin
                     rec_valid            = 1'b1;
                     rec_word.kind        = rdp_pkg::KIND_MEM;
                     rec_word.range_start = min_ff;
                     rec_word.range_end   = max_ff + {data_byte, flen_ff[23:0]} - 32'd1;
                  end
               end
            end
            pos_in = pos_inc;
            if (pos_inc >= len_ff) begin
               phase_in = rdp_pkg::PH_TAG;
            end
         end
         default: begin
            phase_in = rdp_pkg::PH_TAG;
         end
      endcase

      rec_word.entry_number = count_ff;
      count_after = rec_valid ? 7'(count_ff + 7'd1) : count_ff;
      count_in    = count_after;

      // record limit reached: end of list follows on the same byte
      if (phase_ff == rdp_pkg::PH_BODY && count_after >= 7'(MaxResources)) begin
         stop_valid = 1'b1;
         halted     = 1'b1;
         phase_in   = rdp_pkg::PH_HALT;
      end

      // last byte of the buffer closes the list and re-arms
      if (last_byte) begin
         if (!halted) begin
            stop_valid = 1'b1;
         end
         phase_in = rdp_pkg::PH_TAG;
         tag_in   = '0;
         len_in   = '0;
         pos_in   = '0;
         min_in   = '0;
         max_in   = '0;
         flen_in  = '0;
         count_in = '0;
      end

      rec_word.last_result   = ~stop_valid;
      stop_word.kind         = rdp_pkg::KIND_END;
      stop_word.range_start  = '0;
      stop_word.range_end    = '0;
      stop_word.entry_number = count_after;
      stop_word.last_result  = 1'b1;

      parse_out.word0 = rec_valid ? rec_word : stop_word;
      parse_out.word1 = stop_word;
      if (!advance) begin
         parse_out.push_n = 2'd0;
      end else begin
         parse_out.push_n = 2'({1'b0, rec_valid} + {1'b0, stop_valid});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= rdp_pkg::PH_TAG;
         tag_ff   <= '0;
         len_ff   <= '0;
         pos_ff   <= '0;
         min_ff   <= '0;
         max_ff   <= '0;
         flen_ff  <= '0;
         count_ff <= '0;
      end else if (advance) begin
         phase_ff <= phase_in;
         tag_ff   <= tag_in;
         len_ff   <= len_in;
         pos_ff   <= pos_in;
         min_ff   <= min_in;
         max_ff   <= max_in;
         flen_ff  <= flen_in;
         count_ff <= count_in;
      end
   end

endmodule

/* sv/rdp_queue.sv */
module rdp_queue (
   input  logic                                        clock,
   input  logic                                        reset,
   input  rdp_pkg::parse_out_type                      parse_out,
   input  logic                                        pop,
   output rdp_pkg::result_type                         head,
   output logic [$clog2(rdp_pkg::QUEUE_DEPTH+1)-1:0]   level
);

   localparam int PtrW   = $clog2(rdp_pkg::QUEUE_DEPTH);
   localparam int LevelW = $clog2(rdp_pkg::QUEUE_DEPTH + 1);

   rdp_pkg::result_type slot_ff [rdp_pkg::QUEUE_DEPTH];
   logic [PtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [LevelW-1:0] level_ff, level_in;
   logic [PtrW-1:0]   wr_next;

   always_comb begin
      wr_next   = PtrW'(wr_ptr_ff + 1'b1);
      wr_ptr_in = PtrW'(wr_ptr_ff + PtrW'(parse_out.push_n));
      rd_ptr_in = pop ? PtrW'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      level_in  = LevelW'(level_ff + LevelW'(parse_out.push_n) - LevelW'(pop));
   end

   always_ff @(posedge clock) begin
      if (parse_out.push_n != 2'd0) begin
         slot_ff[wr_ptr_ff] <= parse_out.word0;
      end
      if (parse_out.push_n == 2'd2) begin
         slot_ff[wr_next] <= parse_out.word1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   assign head  = slot_ff[rd_ptr_ff];
   assign level = level_ff;

endmodule

/* sv/acpi_resource_descriptor_parser.sv */
// channel   dir  handshake     words
// req_chan  in   valid/ready   data_byte[8], last_byte[1]
// rsp_chan  out  valid/ready   kind[2], range_start[32], range_end[32],
//                              entry_number[7], last_result[1]
//
// one template byte per cycle while the result queue has room; a byte is held in the input register,
// is parsed into the result queue when it advances and its first word can then be taken from the queue
// words leave the queue one per cycle while rsp ready is high; a byte closing a record and the list yields two
// synchronous reset returns the parser to expecting a descriptor tag, record count zero
// rsp stalls fill the four-word result queue; req_ready drops only when fewer than
// two free slots would remain for the byte waiting in the input register
module acpi_resource_descriptor_parser #(
   parameter int MAX_RESOURCES = 8
) (
   input  logic       clock,
   input  logic       reset,
   rdp_req_if.sink    req_chan,
   rdp_rsp_if.source  rsp_chan
);

   localparam int LevelW = $clog2(rdp_pkg::QUEUE_DEPTH + 1);

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;

   logic                   advance;
   logic                   req_take;
   logic                   rsp_pop;
   logic [LevelW-1:0]      level;
   rdp_pkg::parse_out_type parse_out;
   rdp_pkg::result_type    head;

   // room for the worst case of two words from the byte in the input register
   assign advance  = in_valid_ff && (level <= LevelW'(rdp_pkg::QUEUE_DEPTH - 2));
   assign req_take = req_chan.valid && req_chan.ready;
   assign req_chan.ready = ~in_valid_ff | advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   // payload holds while a byte waits
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_chan.data_byte;
         in_last_ff <= req_chan.last_byte;
      end
   end

   // descriptor framing and field extraction
   rdp_parse #(
      .MaxResources(MAX_RESOURCES)
   ) u_parse (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .data_byte (in_byte_ff),
      .last_byte (in_last_ff),
      .parse_out (parse_out)
   );

   // result words waiting for the consumer
   rdp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .parse_out (parse_out),
      .pop       (rsp_pop),
      .head      (head),
      .level     (level)
   );

   assign rsp_pop               = rsp_chan.valid && rsp_chan.ready;
   assign rsp_chan.valid        = (level != '0);
   assign rsp_chan.kind         = head.kind;
   assign rsp_chan.range_start  = head.range_start;
   assign rsp_chan.range_end    = head.range_end;
   assign rsp_chan.entry_number = head.entry_number;
   assign rsp_chan.last_result  = head.last_result;

   // end of list is always the final word of its byte
   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.kind == rdp_pkg::KIND_END |-> rsp_chan.last_result)
      else $error("end record without last_result");

   // a record index stays below the limit, the end count never exceeds it
   a_entry_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |->
         (rsp_chan.kind == rdp_pkg::KIND_END && rsp_chan.entry_number <= 7'(MAX_RESOURCES)) ||
         (rsp_chan.kind != rdp_pkg::KIND_END && rsp_chan.entry_number < 7'(MAX_RESOURCES)))
      else $error("entry number out of range");

   // queue never overfills
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      level <= LevelW'(rdp_pkg::QUEUE_DEPTH))
      else $error("result queue overflow");

   // a waiting byte is neither lost nor overwritten
   a_hold_byte: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_byte_ff) && $stable(in_last_ff))
      else $error("input byte lost while waiting");

endmodule
